FILE: hw/rtl/brsc_pkg.sv
// Shared types, constants and helper functions for the Banker's safety check block.
package brsc_pkg;

    localparam int MAX_PROCESSES = 8;
    localparam int MAX_RESOURCES = 8;
    localparam int PIDX_W        = $clog2(MAX_PROCESSES);
    localparam int RIDX_W        = $clog2(MAX_RESOURCES);
    localparam int CELLS         = MAX_PROCESSES * MAX_RESOURCES;
    localparam int CELL_W        = PIDX_W + RIDX_W;
    localparam int UNIT_W        = 16;
    localparam int CNT_W         = 4;

    localparam logic [1:0] ACT_AVAIL = 2'd0;
    localparam logic [1:0] ACT_MAX   = 2'd1;
    localparam logic [1:0] ACT_HELD  = 2'd2;
    localparam logic [1:0] ACT_REQ   = 2'd3;

    localparam logic [1:0] ST_SAFE   = 2'd0;
    localparam logic [1:0] ST_CLAIM  = 2'd1;
    localparam logic [1:0] ST_AVAIL  = 2'd2;
    localparam logic [1:0] ST_UNSAFE = 2'd3;

    localparam logic REG_NUM_PROC = 1'b0;
    localparam logic REG_NUM_RES  = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_CHECK,
        OP_GRANT,
        OP_WALK_INIT,
        OP_PASS,
        OP_FIT_START,
        OP_FIT,
        OP_ADD,
        OP_MARK,
        OP_ROLLBACK
    } brsc_op_t;

    typedef struct packed {
        brsc_op_t            op;
        logic [PIDX_W-1:0]   pidx;
        logic [RIDX_W-1:0]   ridx;
        logic [PIDX_W-1:0]   np_last;
    } brsc_cmd_t;

    typedef struct packed {
        logic                     claim_bad;
        logic                     avail_bad;
        logic                     fits;
        logic                     progress;
        logic                     fin_cur;
        logic                     all_fin;
        logic [MAX_PROCESSES-1:0] finish_mask;
    } brsc_stat_t;

    function automatic logic [UNIT_W-1:0] sat_add(input logic [UNIT_W-1:0] a,
                                                  input logic [UNIT_W-1:0] b);
        logic [UNIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[UNIT_W] ? {UNIT_W{1'b1}} : s[UNIT_W-1:0];
    endfunction

    // Zero counts as one; values above the storage size count as the storage size.
    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] top);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (v > top)
        begin
            r = top;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/brsc_datapath.sv
// Datapath: claim and allocation memories, vectors, and the compare/add units.
module brsc_datapath
    import brsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  brsc_cmd_t         cmd,
    input  logic [1:0]        action,
    input  logic [UNIT_W-1:0] amount,
    output brsc_stat_t        stat
);

    logic [UNIT_W-1:0] max_mem  [CELLS];
    logic [UNIT_W-1:0] held_mem [CELLS];
    logic [CELLS-1:0]  max_vld_reg;
    logic [CELLS-1:0]  held_vld_reg;

    logic [UNIT_W-1:0] rd_max_raw_reg;
    logic [UNIT_W-1:0] rd_held_raw_reg;
    logic              rd_max_v_reg;
    logic              rd_held_v_reg;

    logic [UNIT_W-1:0] avail_reg [MAX_RESOURCES];
    logic [UNIT_W-1:0] work_reg  [MAX_RESOURCES];
    logic [UNIT_W-1:0] req_reg   [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] fin_reg;
    logic claim_bad_reg;
    logic avail_bad_reg;
    logic fits_reg;
    logic progress_reg;

    logic [CELL_W-1:0] addr;
    logic [UNIT_W-1:0] rd_max;
    logic [UNIT_W-1:0] rd_held;
    logic [UNIT_W-1:0] need;
    logic [UNIT_W-1:0] req_cur;
    logic [UNIT_W-1:0] avail_cur;
    logic [UNIT_W-1:0] work_cur;
    logic              max_we;
    logic              held_we;
    logic [UNIT_W-1:0] held_wd;
    logic [MAX_PROCESSES-1:0] in_use;

    assign addr      = {cmd.pidx, cmd.ridx};
    assign rd_max    = rd_max_v_reg ? rd_max_raw_reg : '0;
    assign rd_held   = rd_held_v_reg ? rd_held_raw_reg : '0;
    assign need      = (rd_max > rd_held) ? (rd_max - rd_held) : '0;
    assign req_cur   = req_reg[cmd.ridx];
    assign avail_cur = avail_reg[cmd.ridx];
    assign work_cur  = work_reg[cmd.ridx];
    assign max_we    = (cmd.op == OP_LOAD) && (action == ACT_MAX);

    always_comb
    begin
        held_we = 1'b0;
        held_wd = amount;
        unique case (cmd.op)
            OP_LOAD:
            begin
                held_we = (action == ACT_HELD);
                held_wd = amount;
            end
            OP_GRANT:
            begin
                held_we = 1'b1;
                held_wd = sat_add(rd_held, req_cur);
            end
            OP_ROLLBACK:
            begin
                held_we = 1'b1;
                held_wd = rd_held - req_cur;
            end
            default:
            begin
                held_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < MAX_PROCESSES; i++)
        begin
            in_use[i] = (PIDX_W'(i) <= cmd.np_last);
        end
    end

    // Memories and request buffer hold no reset; memory entries carry valid bits instead, the request buffer has none.
    always_ff @(posedge clk)
    begin
        if (max_we)
        begin
            max_mem[addr] <= amount;
        end
        if (held_we)
        begin
            held_mem[addr] <= held_wd;
        end
        if (cmd.op == OP_READ)
        begin
            rd_max_raw_reg  <= max_mem[addr];
            rd_held_raw_reg <= held_mem[addr];
        end
        if ((cmd.op == OP_LOAD) && (action == ACT_REQ))
        begin
            req_reg[cmd.ridx] <= amount;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_vld_reg   <= '0;
            held_vld_reg  <= '0;
            rd_max_v_reg  <= 1'b0;
            rd_held_v_reg <= 1'b0;
            fin_reg       <= '0;
            claim_bad_reg <= 1'b0;
            avail_bad_reg <= 1'b0;
            fits_reg      <= 1'b0;
            progress_reg  <= 1'b0;
            for (int j = 0; j < MAX_RESOURCES; j++)
            begin
                avail_reg[j] <= '0;
                work_reg[j]  <= '0;
            end
        end
        else
        begin
            if (max_we)
            begin
                max_vld_reg[addr] <= 1'b1;
            end
            if (held_we)
            begin
                held_vld_reg[addr] <= 1'b1;
            end
            unique case (cmd.op)
                OP_LOAD:
                begin
                    claim_bad_reg <= 1'b0;
                    avail_bad_reg <= 1'b0;
                    if (action == ACT_AVAIL)
                    begin
                        avail_reg[cmd.ridx] <= amount;
                    end
                end
                OP_READ:
                begin
                    rd_max_v_reg  <= max_vld_reg[addr];
                    rd_held_v_reg <= held_vld_reg[addr];
                end
                OP_CHECK:
                begin
                    if (req_cur > need)
                    begin
                        claim_bad_reg <= 1'b1;
                    end
                    if (req_cur > avail_cur)
                    begin
                        avail_bad_reg <= 1'b1;
                    end
                end
                OP_GRANT:
                begin
                    avail_reg[cmd.ridx] <= avail_cur - req_cur;
                end
                OP_ROLLBACK:
                begin
                    avail_reg[cmd.ridx] <= avail_cur + req_cur;
                end
                OP_WALK_INIT:
                begin
                    for (int j = 0; j < MAX_RESOURCES; j++)
                    begin
                        work_reg[j] <= avail_reg[j];
                    end
                    fin_reg      <= '0;
                    progress_reg <= 1'b0;
                end
                OP_PASS:
                begin
                    progress_reg <= 1'b0;
                end
                OP_FIT_START:
                begin
                    fits_reg <= 1'b1;
                end
                OP_FIT:
                begin
                    if (need > work_cur)
                    begin
                        fits_reg <= 1'b0;
                    end
                end
                OP_ADD:
                begin
                    work_reg[cmd.ridx] <= sat_add(work_cur, rd_held);
                end
                OP_MARK:
                begin
                    fin_reg[cmd.pidx] <= 1'b1;
                    progress_reg      <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.claim_bad   = claim_bad_reg;
    assign stat.avail_bad   = avail_bad_reg;
    assign stat.fits        = fits_reg;
    assign stat.progress    = progress_reg;
    assign stat.fin_cur     = fin_reg[cmd.pidx];
    assign stat.all_fin     = &(fin_reg | ~in_use);
    assign stat.finish_mask = fin_reg & in_use;

endmodule

FILE: hw/rtl/brsc_ctrl.sv
// Controller: configuration registers, sequencing state machine and result register.
module brsc_ctrl
    import brsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [PIDX_W-1:0] process,
    input  logic [RIDX_W-1:0] resource,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [MAX_PROCESSES-1:0] finish_mask,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CNT_W-1:0]  cfg_data,
    output brsc_cmd_t         cmd,
    input  brsc_stat_t        stat
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK_RD,
        S_CHK_EX,
        S_CHK_END,
        S_GR_RD,
        S_GR_EX,
        S_WALK_INIT,
        S_P_CHK,
        S_FIT_RD,
        S_FIT_EX,
        S_FIT_END,
        S_ADD_RD,
        S_ADD_EX,
        S_MARK,
        S_P_NEXT,
        S_WALK_END,
        S_RB_RD,
        S_RB_EX,
        S_EMIT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  np_reg;
    logic [CNT_W-1:0]  nr_reg;
    logic [PIDX_W-1:0] preq_reg;
    logic [PIDX_W-1:0] pi_reg;
    logic [RIDX_W-1:0] rj_reg;
    logic [1:0]        status_reg;
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [MAX_PROCESSES-1:0] out_mask_reg;

    logic [PIDX_W-1:0] np_last;
    logic [RIDX_W-1:0] nr_last;
    logic              in_acc;
    logic              rj_end;
    logic              pi_end;

    assign np_last  = PIDX_W'(clamp_cnt(np_reg, CNT_W'(MAX_PROCESSES)) - CNT_W'(1));
    assign nr_last  = RIDX_W'(clamp_cnt(nr_reg, CNT_W'(MAX_RESOURCES)) - CNT_W'(1));
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign rj_end   = (rj_reg == nr_last);
    assign pi_end   = (pi_reg == np_last);

    always_comb
    begin
        cmd.op      = OP_NONE;
        cmd.pidx    = preq_reg;
        cmd.ridx    = rj_reg;
        cmd.np_last = np_last;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.op   = in_acc ? OP_LOAD : OP_NONE;
                cmd.pidx = process;
                cmd.ridx = resource;
            end
            S_CHK_RD, S_GR_RD, S_RB_RD: cmd.op = OP_READ;
            S_CHK_EX:    cmd.op = OP_CHECK;
            S_GR_EX:     cmd.op = OP_GRANT;
            S_RB_EX:     cmd.op = OP_ROLLBACK;
            S_WALK_INIT: cmd.op = OP_WALK_INIT;
            S_P_CHK:
            begin
                cmd.pidx = pi_reg;
                cmd.op   = OP_FIT_START;
            end
            S_FIT_RD, S_ADD_RD:
            begin
                cmd.pidx = pi_reg;
                cmd.op   = OP_READ;
            end
            S_FIT_EX:
            begin
                cmd.pidx = pi_reg;
                cmd.op   = OP_FIT;
            end
            S_ADD_EX:
            begin
                cmd.pidx = pi_reg;
                cmd.op   = OP_ADD;
            end
            S_MARK:
            begin
                cmd.pidx = pi_reg;
                cmd.op   = OP_MARK;
            end
            S_P_NEXT:
            begin
                cmd.pidx = pi_reg;
                cmd.op   = (pi_end && stat.progress) ? OP_PASS : OP_NONE;
            end
            S_FIT_END, S_CHK_END, S_WALK_END, S_EMIT: cmd.op = OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            np_reg         <= CNT_W'(MAX_PROCESSES);
            nr_reg         <= CNT_W'(MAX_RESOURCES);
            preq_reg       <= '0;
            pi_reg         <= '0;
            rj_reg         <= '0;
            status_reg     <= ST_SAFE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_SAFE;
            out_mask_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_NUM_PROC)
                begin
                    np_reg <= cfg_data;
                end
                else
                begin
                    nr_reg <= cfg_data;
                end
            end
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && (action == ACT_REQ) && last)
                    begin
                        preq_reg  <= process;
                        rj_reg    <= '0;
                        state_reg <= S_CHK_RD;
                    end
                end
                S_CHK_RD: state_reg <= S_CHK_EX;
                S_CHK_EX:
                begin
                    rj_reg    <= rj_reg + RIDX_W'(1);
                    state_reg <= rj_end ? S_CHK_END : S_CHK_RD;
                end
                S_CHK_END:
                begin
                    rj_reg <= '0;
                    priority if (stat.claim_bad)
                    begin
                        status_reg <= ST_CLAIM;
                        state_reg  <= S_EMIT;
                    end
                    else if (stat.avail_bad)
                    begin
                        status_reg <= ST_AVAIL;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_GR_RD;
                    end
                end
                S_GR_RD: state_reg <= S_GR_EX;
                S_GR_EX:
                begin
                    rj_reg    <= rj_reg + RIDX_W'(1);
                    state_reg <= rj_end ? S_WALK_INIT : S_GR_RD;
                end
                S_WALK_INIT:
                begin
                    pi_reg    <= '0;
                    state_reg <= S_P_CHK;
                end
                S_P_CHK:
                begin
                    rj_reg    <= '0;
                    state_reg <= stat.fin_cur ? S_P_NEXT : S_FIT_RD;
                end
                S_FIT_RD: state_reg <= S_FIT_EX;
                S_FIT_EX:
                begin
                    rj_reg    <= rj_reg + RIDX_W'(1);
                    state_reg <= rj_end ? S_FIT_END : S_FIT_RD;
                end
                S_FIT_END:
                begin
                    rj_reg    <= '0;
                    state_reg <= stat.fits ? S_ADD_RD : S_P_NEXT;
                end
                S_ADD_RD: state_reg <= S_ADD_EX;
                S_ADD_EX:
                begin
                    rj_reg    <= rj_reg + RIDX_W'(1);
                    state_reg <= rj_end ? S_MARK : S_ADD_RD;
                end
                S_MARK: state_reg <= S_P_NEXT;
                S_P_NEXT:
                begin
                    priority if (!pi_end)
                    begin
                        pi_reg    <= pi_reg + PIDX_W'(1);
                        state_reg <= S_P_CHK;
                    end
                    else if (stat.progress)
                    begin
                        pi_reg    <= '0;
                        state_reg <= S_P_CHK;
                    end
                    else
                    begin
                        state_reg <= S_WALK_END;
                    end
                end
                S_WALK_END:
                begin
                    rj_reg <= '0;
                    if (stat.all_fin)
                    begin
                        status_reg <= ST_SAFE;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        status_reg <= ST_UNSAFE;
                        state_reg  <= S_RB_RD;
                    end
                end
                S_RB_RD: state_reg <= S_RB_EX;
                S_RB_EX:
                begin
                    rj_reg    <= rj_reg + RIDX_W'(1);
                    state_reg <= rj_end ? S_EMIT : S_RB_RD;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_mask_reg   <= ((status_reg == ST_CLAIM) || (status_reg == ST_AVAIL))
                                          ? '0 : stat.finish_mask;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign finish_mask = out_mask_reg;

`ifndef SYNTHESIS
    a_req_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (action == ACT_REQ) && last) |=> (state_reg == S_CHK_RD))
        else $error("final request element did not start the check");

    a_claim_reject: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CHK_END) && stat.claim_bad)
            |=> ((state_reg == S_EMIT) && (status_reg == ST_CLAIM)))
        else $error("claim violation not reported");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_EMIT))
        else $error("result produced outside emit state");

    a_reject_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_status_reg == ST_CLAIM) || (out_status_reg == ST_AVAIL)))
            |-> (out_mask_reg == '0))
        else $error("rejected request shows a finish mask");
`endif

endmodule

FILE: hw/rtl/bankers_request_safety_check_core.sv
// Top level of the Banker's deadlock-avoidance request checker.
//
// Usage: the input channel (in_valid / in_stall) carries one request per
// accepted handshake: action 0 loads an available count, 1 a maximum claim,
// 2 an allocation, and 3 one element of a resource request. A request
// element with last set starts the check: claim and availability compare,
// tentative grant, safety walk, and rollback if the state is unsafe.
// Exactly one result then appears on the output channel (out_valid /
// out_stall) with the status and the finish mask. The sequencer handles
// one resource element at a time through the single read port of the
// claim and allocation memories, reading each element before using it.
// Input is stalled while a check runs. The result is held in an output
// register; a stalled receiver keeps it there, and the block keeps
// accepting loads meanwhile. Reset makes the available, claim and
// allocation tables read as zero, does not clear the request buffer,
// sets both counts to 8 and drops out_valid. Configuration is written
// through cfg_we / cfg_index / cfg_data; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module bankers_request_safety_check_core
    import brsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               action,
    input  logic [2:0]               process,
    input  logic [2:0]               resource,
    input  logic [15:0]              amount,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [7:0]               finish_mask,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [3:0]               cfg_data
);

    // Command and status buses between the sequencer and the datapath.
    brsc_cmd_t  cmd;
    brsc_stat_t stat;

    brsc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .process     (process),
        .resource    (resource),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .finish_mask (finish_mask),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat)
    );

    // The datapath owns every table; loads reach it straight from the input port.
    brsc_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .action (action),
        .amount (amount),
        .stat   (stat)
    );

endmodule

FILE: tb/bankers_request_safety_check_core_tb.sv
// Self-checking testbench for the Banker's request safety check core.
`timescale 1ns / 1ps

module bankers_request_safety_check_core_tb;
    import brsc_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int ITEM_TARGET = 600;

    // One expected check result: the status and the mask of processes that could finish.
    typedef struct {
        logic [1:0] status;
        logic [7:0] mask;
    } verdict_t;

    // The scoreboard keeps its own copy of the banker tables and the two counts.
    // Every accepted request is applied to that copy; a final request element
    // queues the verdict that the core has to produce.
    class banker_scoreboard;
        logic [15:0] avail[8];
        logic [15:0] claim[8][8];
        logic [15:0] held[8][8];
        logic [15:0] need[8][8];
        logic [15:0] req_vec[8];
        logic [3:0]  proc_cnt;
        logic [3:0]  res_cnt;
        verdict_t    pending[$];
        int          errors;

        function new();
            proc_cnt = 4'd8;
            res_cnt  = 4'd8;
            errors   = 0;
            for (int i = 0; i < 8; i++)
            begin
                avail[i]   = '0;
                req_vec[i] = '0;
                for (int j = 0; j < 8; j++)
                begin
                    claim[i][j] = '0;
                    held[i][j]  = '0;
                    need[i][j]  = '0;
                end
            end
        endfunction

        function void report(string what);
            errors++;
            $display("MISMATCH: %s", what);
        endfunction

        function int used_count(logic [3:0] v);
            if (v == 4'd0)
            begin
                return 1;
            end
            return (v > 4'd8) ? 8 : int'(v);
        endfunction

        function logic [15:0] add_clip(logic [15:0] a, logic [15:0] b);
            logic [16:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[16] ? 16'hFFFF : s[15:0];
        endfunction

        function void set_count(logic idx, logic [3:0] value);
            if (idx == REG_NUM_PROC)
            begin
                proc_cnt = value;
            end
            else
            begin
                res_cnt = value;
            end
        endfunction

        // Runs the check that a final request element triggers.
        function void judge(int p);
            int          np;
            int          nr;
            logic [15:0] work[8];
            logic [15:0] keep_avail[8];
            logic [15:0] keep_held[8];
            logic [15:0] keep_need[8];
            bit          done_proc[8];
            bit          moved;
            bit          fits;
            bit          all_done;
            logic [7:0]  mask;
            verdict_t    v;
            np = used_count(proc_cnt);
            nr = used_count(res_cnt);
            for (int j = 0; j < nr; j++)
            begin
                if (req_vec[j] > need[p][j])
                begin
                    v.status = ST_CLAIM;
                    v.mask   = '0;
                    pending.push_back(v);
                    return;
                end
            end
            for (int j = 0; j < nr; j++)
            begin
                if (req_vec[j] > avail[j])
                begin
                    v.status = ST_AVAIL;
                    v.mask   = '0;
                    pending.push_back(v);
                    return;
                end
            end
            // Tentative grant.
            for (int j = 0; j < nr; j++)
            begin
                keep_avail[j] = avail[j];
                keep_held[j]  = held[p][j];
                keep_need[j]  = need[p][j];
                avail[j]      = avail[j] - req_vec[j];
                held[p][j]    = add_clip(held[p][j], req_vec[j]);
                need[p][j]    = need[p][j] - req_vec[j];
            end
            // Safety walk: keep passing over the processes until none can finish.
            for (int j = 0; j < 8; j++)
            begin
                work[j] = avail[j];
            end
            for (int i = 0; i < 8; i++)
            begin
                done_proc[i] = 1'b0;
            end
            moved = 1'b1;
            while (moved)
            begin
                moved = 1'b0;
                for (int i = 0; i < np; i++)
                begin
                    if (!done_proc[i])
                    begin
                        fits = 1'b1;
                        for (int j = 0; j < nr; j++)
                        begin
                            if (need[i][j] > work[j])
                            begin
                                fits = 1'b0;
                            end
                        end
                        if (fits)
                        begin
                            for (int j = 0; j < nr; j++)
                            begin
                                work[j] = add_clip(work[j], held[i][j]);
                            end
                            done_proc[i] = 1'b1;
                            moved = 1'b1;
                        end
                    end
                end
            end
            mask     = '0;
            all_done = 1'b1;
            for (int i = 0; i < np; i++)
            begin
                mask[i] = done_proc[i];
                if (!done_proc[i])
                begin
                    all_done = 1'b0;
                end
            end
            v.mask = mask;
            if (all_done)
            begin
                v.status = ST_SAFE;
            end
            else
            begin
                v.status = ST_UNSAFE;
                for (int j = 0; j < nr; j++)
                begin
                    avail[j]   = keep_avail[j];
                    held[p][j] = keep_held[j];
                    need[p][j] = keep_need[j];
                end
            end
            pending.push_back(v);
        endfunction

        function void note_request(logic [1:0] act, logic [2:0] p, logic [2:0] r,
                                   logic [15:0] amt, logic fin);
            case (act)
                ACT_AVAIL: avail[r] = amt;
                ACT_MAX, ACT_HELD:
                begin
                    if (act == ACT_MAX)
                    begin
                        claim[p][r] = amt;
                    end
                    else
                    begin
                        held[p][r] = amt;
                    end
                    need[p][r] = (claim[p][r] > held[p][r]) ? claim[p][r] - held[p][r] : '0;
                end
                default:
                begin
                    req_vec[r] = amt;
                    if (fin)
                    begin
                        judge(int'(p));
                    end
                end
            endcase
        endfunction

        function void check_result(logic [1:0] st, logic [7:0] mask);
            verdict_t v;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result status=%0d mask=%02h", st, mask));
                return;
            end
            v = pending.pop_front();
            if (st !== v.status)
            begin
                report($sformatf("status %0d, expected %0d", st, v.status));
            end
            if (mask !== v.mask)
            begin
                report($sformatf("finish_mask %02h, expected %02h", mask, v.mask));
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_action;
    logic [2:0]  req_proc;
    logic [2:0]  req_res;
    logic [15:0] req_amount;
    logic        req_last;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [7:0]  finish_mask;
    logic        cfg_we;
    logic        cfg_index;
    logic [3:0]  cfg_data;

    banker_scoreboard board;
    int          cycles;
    int          sent;
    bit          send_gaps;
    bit          recv_gaps;
    int          procs_now;
    int          res_now;

    bankers_request_safety_check_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (req_action),
        .process    (req_proc),
        .resource   (req_res),
        .amount     (req_amount),
        .last       (req_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .finish_mask(finish_mask),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Every result handshake is checked against the oldest queued verdict.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_result(status, finish_mask);
        end
    end

    // Receiver: stalls a random number of cycles before taking each result,
    // unless the current phase runs without gaps.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = recv_gaps ? $urandom_range(0, 12) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
        end
    end

    // Presents one request and holds it until the core accepts it. The task
    // returns on the edge that accepts the request, so in_valid stays high
    // when the next request follows with no gap.
    task automatic send_request(logic [1:0] act, logic [2:0] p, logic [2:0] r,
                                logic [15:0] amt, logic fin);
        int gap;
        gap = send_gaps ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_action <= act;
        req_proc   <= p;
        req_res    <= r;
        req_amount <= amt;
        req_last   <= fin;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        board.note_request(act, p, r, amt, fin);
        sent++;
    endtask

    // Holds the sender back until every queued verdict has been matched, then
    // keeps waiting so that any trailing load has settled.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    // Writes one count register; only called while the core is idle.
    task automatic write_count(logic idx, logic [3:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_count(idx, value);
        @(posedge clk);
    endtask

    function automatic logic [15:0] small_units();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            return 16'hFFFF;
        end
        if (pick < 8)
        begin
            return 16'($urandom());
        end
        return 16'($urandom_range(0, 12));
    endfunction

    // One request vector for a process: an element per resource type in use,
    // with last on the final one. Amounts are kept small so that many grants
    // succeed and the walk gets exercised.
    task automatic request_vector(logic [2:0] p);
        for (int j = 0; j < res_now; j++)
        begin
            send_request(ACT_REQ, p, 3'(j), 16'($urandom_range(0, 4)), j == res_now - 1);
        end
    endtask

    initial
    begin
        logic [3:0] counts[4];
        int         phase_end;
        int         pick;
        board      = new();
        cycles     = 0;
        sent       = 0;
        send_gaps  = 1'b1;
        recv_gaps  = 1'b1;
        in_valid   = 1'b0;
        req_action = ACT_AVAIL;
        req_proc   = '0;
        req_res    = '0;
        req_amount = '0;
        req_last   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_NUM_PROC;
        cfg_data   = '0;
        rst_n      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with both counts at their reset value of eight.
        // Every request buffer entry is written first; the last one closes a
        // zero request that must pass on an empty state.
        for (int j = 0; j < 8; j++)
        begin
            send_request(ACT_REQ, 3'd0, 3'(j), 16'd0, j == 7);
        end
        send_request(ACT_AVAIL, 3'd0, 3'd7, 16'hFFFF, 1'b0);
        send_request(ACT_MAX, 3'd7, 3'd7, 16'hFFFF, 1'b0);
        send_request(ACT_HELD, 3'd7, 3'd7, 16'd1, 1'b0);
        // Allocation above the claim leaves the need at zero and makes the
        // work sums saturate during the walk.
        send_request(ACT_HELD, 3'd0, 3'd0, 16'hFFFF, 1'b0);
        // Asking for more than the remaining need is refused as over claim.
        send_request(ACT_REQ, 3'd7, 3'd7, 16'hFFFF, 1'b1);
        send_request(ACT_REQ, 3'd7, 3'd7, 16'd100, 1'b1);
        send_request(ACT_REQ, 3'd3, 3'd0, 16'd5, 1'b1);
        send_request(ACT_MAX, 3'd3, 3'd0, 16'd5, 1'b0);
        // Still over claim: the buffered element 7 of 100 exceeds its zero need.
        send_request(ACT_REQ, 3'd3, 3'd0, 16'd5, 1'b1);
        // A last flag on a load does nothing.
        send_request(ACT_AVAIL, 3'd0, 3'd0, 16'd5, 1'b1);
        send_request(ACT_REQ, 3'd3, 3'd0, 16'd5, 1'b1);
        // A claim nobody can ever satisfy makes any grant unsafe.
        send_request(ACT_MAX, 3'd5, 3'd1, 16'd9, 1'b0);
        send_request(ACT_REQ, 3'd2, 3'd0, 16'd0, 1'b0);
        send_request(ACT_REQ, 3'd2, 3'd7, 16'd0, 1'b1);
        // Hold off until every verdict is back before touching the counts.
        drain();

        counts = '{4'd0, 4'd1, 4'd8, 4'd15};
        while (sent < ITEM_TARGET)
        begin
            drain();
            // The extreme count values come first, then random ones.
            if (sent < 200)
            begin
                write_count(REG_NUM_PROC, counts[$urandom_range(0, 3)]);
                write_count(REG_NUM_RES, counts[$urandom_range(0, 3)]);
            end
            else
            begin
                write_count(REG_NUM_PROC, 4'($urandom_range(0, 15)));
                write_count(REG_NUM_RES, 4'($urandom_range(0, 15)));
            end
            procs_now = board.used_count(board.proc_cnt);
            res_now   = board.used_count(board.res_cnt);
            send_gaps = $urandom_range(0, 3) != 0;
            recv_gaps = $urandom_range(0, 3) != 0;
            phase_end = sent + 60;
            while (sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    send_request(2'($urandom_range(0, 2)), 3'($urandom_range(0, procs_now - 1)),
                                 3'($urandom_range(0, res_now - 1)), small_units(),
                                 1'($urandom()));
                end
                else if (pick < 85)
                begin
                    // Mostly processes in use, now and then one outside the count.
                    request_vector($urandom_range(0, 9) == 0 ? 3'($urandom()) :
                                   3'($urandom_range(0, procs_now - 1)));
                end
                else
                begin
                    // Noise: any action, any index, any amount, any last flag.
                    send_request(2'($urandom()), 3'($urandom()), 3'($urandom()),
                                 16'($urandom()), 1'($urandom()));
                end
            end
        end

        drain();
        if (board.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/brsc_pkg.sv
hw/rtl/brsc_datapath.sv
hw/rtl/brsc_ctrl.sv
hw/rtl/bankers_request_safety_check_core.sv
tb/bankers_request_safety_check_core_tb.sv
